// File: src/rgb_layer_blend_unit_assert.svh
`ifndef RGB_LAYER_BLEND_UNIT_ASSERT_SVH
`define RGB_LAYER_BLEND_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define RLB_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RLB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/rlb_pkg.sv
package rlb_pkg;

    localparam int unsigned CH_W             = 8;
    localparam int unsigned FIELD_COUNT      = 3;
    localparam int unsigned DEFAULT_CHANNELS = 3;
    localparam int unsigned MODE_W           = 3;

    localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

    localparam int unsigned      X_W        = CH_W + 1;
    localparam int unsigned      T_W        = 18;
    localparam logic [T_W-1:0]   ROUND_BIAS = 18'd127;
    localparam int unsigned      DIV_SHIFT  = 25;
    localparam logic [T_W-1:0]   DIV_MUL    = 18'd131587;
    localparam int unsigned      PROD_W     = 2 * T_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD      = 3'd0,
        MODE_SUBTRACT = 3'd1,
        MODE_MULTIPLY = 3'd2,
        MODE_SCREEN   = 3'd3,
        MODE_OVERLAY  = 3'd4
    } blend_mode_t;

    typedef struct packed {
        logic            use_prod;
        logic            inv;
        logic [CH_W-1:0] simple;
    } lane_ctl_t;

    typedef struct packed {
        logic [X_W-1:0]  x;
        logic [CH_W-1:0] y;
        lane_ctl_t       ctl;
    } lane_op_t;

endpackage

// File: src/rlb_if.sv
interface rlb_pix_in_if;
    import rlb_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] base_blue;
    logic [CH_W-1:0] base_green;
    logic [CH_W-1:0] base_red;
    logic [CH_W-1:0] top_blue;
    logic [CH_W-1:0] top_green;
    logic [CH_W-1:0] top_red;

    modport source (
        output valid, base_blue, base_green, base_red, top_blue, top_green, top_red,
        input  ready
    );
    modport sink (
        input  valid, base_blue, base_green, base_red, top_blue, top_green, top_red,
        output ready
    );
endinterface

interface rlb_pix_out_if;
    import rlb_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;

    modport source (
        output valid, out_blue, out_green, out_red,
        input  ready
    );
    modport sink (
        input  valid, out_blue, out_green, out_red,
        output ready
    );
endinterface

interface rlb_cfg_if;
    import rlb_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] blend_mode;

    modport source (
        output valid, blend_mode,
        input  ready
    );
    modport sink (
        input  valid, blend_mode,
        output ready
    );
endinterface

// File: src/rgb_layer_blend_unit.sv
// Throughput: one item per cycle unless the output stalls; the four stages (operand select,
// product, reciprocal multiply for the divide by 255, output select) each hold one item and
// stall independently. Reset: rst_n is asynchronous and active low; it clears all stage
// valid bits and sets the blend mode to add. The configuration channel is always ready.
`include "rgb_layer_blend_unit_assert.svh"

module rgb_layer_blend_unit #(
    parameter int unsigned CHANNELS = rlb_pkg::DEFAULT_CHANNELS
) (
    input  logic          clk,
    input  logic          rst_n,
    rlb_cfg_if.sink       cfg,
    rlb_pix_in_if.sink    pix_in,
    rlb_pix_out_if.source pix_out
);
    import rlb_pkg::*;

    localparam int unsigned LANES = (CHANNELS < FIELD_COUNT) ? CHANNELS : FIELD_COUNT;

    blend_mode_t mode_reg;

    logic [CH_W-1:0] base_ch [FIELD_COUNT];
    logic [CH_W-1:0] top_ch  [FIELD_COUNT];
    logic [CH_W-1:0] out_ch  [FIELD_COUNT];

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic adv1, adv2, adv3, adv4;

    lane_op_t        s1_op_reg  [LANES];
    logic [T_W-1:0]  s2_t_reg   [LANES];
    lane_ctl_t       s2_ctl_reg [LANES];
    logic [CH_W-1:0] s3_q_reg   [LANES];
    lane_ctl_t       s3_ctl_reg [LANES];
    logic [CH_W-1:0] out_reg    [LANES];

    function automatic lane_op_t prep(blend_mode_t m, logic [CH_W-1:0] a, logic [CH_W-1:0] b);
        lane_op_t       r;
        logic [CH_W:0]  sum;
        r.x            = '0;
        r.y            = '0;
        r.ctl.use_prod = 1'b0;
        r.ctl.inv      = 1'b0;
        r.ctl.simple   = '0;
        sum            = {1'b0, a} + {1'b0, b};
        unique case (m)
            MODE_ADD: r.ctl.simple = sum[CH_W] ? CH_MAX : sum[CH_W-1:0];
            MODE_SUBTRACT: r.ctl.simple = (a > b) ? (a - b) : '0;
            MODE_MULTIPLY:
            begin
                r.ctl.use_prod = 1'b1;
                r.x            = {1'b0, a};
                r.y            = b;
            end
            MODE_SCREEN:
            begin
                r.ctl.use_prod = 1'b1;
                r.ctl.inv      = 1'b1;
                r.x            = {1'b0, ~a};
                r.y            = ~b;
            end
            MODE_OVERLAY:
            begin
                r.ctl.use_prod = 1'b1;
                if (!a[CH_W-1])
                begin
                    r.x = {a, 1'b0};
                    r.y = b;
                end
                else
                begin
                    r.ctl.inv = 1'b1;
                    r.x       = {~a, 1'b0};
                    r.y       = ~b;
                end
            end
            default: r.ctl.simple = '0;
        endcase
        return r;
    endfunction

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ADD;
        end
        else if (cfg.valid && cfg.ready)
        begin
            mode_reg <= blend_mode_t'(cfg.blend_mode);
        end
    end

    assign base_ch[0] = pix_in.base_blue;
    assign base_ch[1] = pix_in.base_green;
    assign base_ch[2] = pix_in.base_red;
    assign top_ch[0]  = pix_in.top_blue;
    assign top_ch[1]  = pix_in.top_green;
    assign top_ch[2]  = pix_in.top_red;

    assign adv4          = !out_valid_reg || pix_out.ready;
    assign adv3          = !s3_valid_reg || adv4;
    assign adv2          = !s2_valid_reg || adv3;
    assign adv1          = !s1_valid_reg || adv2;
    assign pix_in.ready  = adv1;
    assign pix_out.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= pix_in.valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (adv4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [T_W-1:0]    t_next;
        logic [PROD_W-1:0] prod;

        assign t_next = T_W'(s1_op_reg[g].x * s1_op_reg[g].y) + ROUND_BIAS;
        assign prod   = PROD_W'(s2_t_reg[g]) * PROD_W'(DIV_MUL);

        always_ff @(posedge clk)
        begin
            if (adv1)
            begin
                s1_op_reg[g] <= prep(mode_reg, base_ch[g], top_ch[g]);
            end
            if (adv2)
            begin
                s2_t_reg[g]   <= t_next;
                s2_ctl_reg[g] <= s1_op_reg[g].ctl;
            end
            if (adv3)
            begin
                s3_q_reg[g]   <= prod[DIV_SHIFT+CH_W-1:DIV_SHIFT];
                s3_ctl_reg[g] <= s2_ctl_reg[g];
            end
            if (adv4)
            begin
                if (!s3_ctl_reg[g].use_prod)
                begin
                    out_reg[g] <= s3_ctl_reg[g].simple;
                end
                else if (s3_ctl_reg[g].inv)
                begin
                    out_reg[g] <= ~s3_q_reg[g];
                end
                else
                begin
                    out_reg[g] <= s3_q_reg[g];
                end
            end
        end
    end

    for (genvar k = 0; k < FIELD_COUNT; k++)
    begin : g_out
        if (k < LANES)
        begin : g_used
            assign out_ch[k] = out_reg[k];
        end
        else
        begin : g_zero
            assign out_ch[k] = '0;
        end
    end

    assign pix_out.out_blue  = out_ch[0];
    assign pix_out.out_green = out_ch[1];
    assign pix_out.out_red   = out_ch[2];

    `RLB_ASSERT_CLK(a_in_enters_s1, pix_in.valid && pix_in.ready |=> s1_valid_reg, "accepted item did not reach stage 1")
    `RLB_ASSERT_CLK(a_s3_to_out, s3_valid_reg && !out_valid_reg |=> out_valid_reg, "stage 3 item did not reach output")
    `RLB_ASSERT_CLK(a_mode_hold, !(cfg.valid && cfg.ready) |=> $stable(mode_reg), "blend mode changed without a write")
    `RLB_ASSERT_ALWAYS(a_out_from_pipe, $rose(out_valid_reg) |-> $past(s3_valid_reg), "output valid without a stage 3 item")

endmodule
